FILE: src/pae_pkg.sv
// shared types, operation codes and character constants of the expression evaluator
package pae_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   localparam int OP_WIDTH = 3;
   localparam logic [OP_WIDTH-1:0] OP_IGNORE = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_DIGIT  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_PLUS   = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_MINUS  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_OPEN   = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_CLOSE  = 3'd5;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] total;
      logic                         error;
   } rsp_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic [3:0]          digit;
      logic                last;
   } op_item_type;

endpackage

FILE: src/pae_front.sv
// front end: classifies each character and queues the decoded operation
module pae_front
   import pae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        op_valid,
   input  logic        op_ready,
   output op_item_type op_item
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_item_type       decoded;
   op_item_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              push, pop;

   // character decode
   always_comb begin
      decoded.digit = 4'(req_payload.character - CHAR_ZERO);
      decoded.last  = req_payload.last_char;
      if (req_payload.character >= CHAR_ZERO && req_payload.character <= CHAR_NINE) begin
         decoded.op = OP_DIGIT;
      end else if (req_payload.character == CHAR_PLUS) begin
         decoded.op = OP_PLUS;
      end else if (req_payload.character == CHAR_MINUS) begin
         decoded.op = OP_MINUS;
      end else if (req_payload.character == CHAR_OPEN) begin
         decoded.op = OP_OPEN;
      end else if (req_payload.character == CHAR_CLOSE) begin
         decoded.op = OP_CLOSE;
      end else begin
         decoded.op = OP_IGNORE;
      end
   end

   assign req_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign op_valid  = (count_ff != '0);
   assign op_item   = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: src/pae_back.sv
// back end: executes decoded operations on the sums and the parenthesis stack
module pae_back
   import pae_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        op_valid,
   output logic        op_ready,
   input  op_item_type op_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = WORD_WIDTH + 1;

   logic [WORD_WIDTH-1:0] sum_ff, sum_in;
   logic [WORD_WIDTH-1:0] cur_ff, cur_in;
   logic                  neg_ff, neg_in;
   logic [LW-1:0]         level_ff, level_in;
   logic                  err_ff, err_in;
   logic [SW-1:0]         tos_ff, tos_in;
   logic [SW-1:0]         below_ff;
   logic [SW-1:0]         mem [DEPTH];
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                  fire;
   logic [WORD_WIDTH-1:0] folded;
   logic [WORD_WIDTH-1:0] final_sum;
   logic                  final_err;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [SW-1:0]         wr_data;
   logic [LW-1:0]         rd_level;
   logic [AW-1:0]         rd_addr;

   // a last item needs a free output slot
   assign op_ready    = !op_item.last || !rsp_valid_ff || rsp_ready;
   assign fire        = op_valid && op_ready;
   assign folded      = sum_ff + (neg_ff ? (WORD_WIDTH'(0) - cur_ff) : cur_ff);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      sum_in   = sum_ff;
      cur_in   = cur_ff;
      neg_in   = neg_ff;
      level_in = level_ff;
      err_in   = err_ff;
      tos_in   = tos_ff;
      wr_en    = 1'b0;
      wr_addr  = level_ff[AW-1:0];
      wr_data  = {neg_ff, folded};
      if (fire) begin
         case (op_item.op)
            OP_DIGIT: begin
               cur_in = (cur_ff << 3) + (cur_ff << 1) + WORD_WIDTH'(op_item.digit);
            end
            OP_PLUS, OP_MINUS: begin
               sum_in = folded;
               cur_in = '0;
               neg_in = (op_item.op == OP_MINUS);
            end
            OP_OPEN: begin
               sum_in = folded;
               cur_in = '0;
               if (level_ff == LW'(DEPTH)) begin
                  err_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  tos_in   = wr_data;
                  level_in = level_ff + 1'b1;
                  sum_in   = '0;
                  neg_in   = 1'b0;
               end
            end
            OP_CLOSE: begin
               sum_in = folded;
               cur_in = '0;
               neg_in = 1'b0;
               if (level_ff == '0) begin
                  err_in = 1'b1;
               end else begin
                  level_in = level_ff - 1'b1;
                  sum_in   = tos_ff[WORD_WIDTH-1:0] +
                             (tos_ff[WORD_WIDTH] ? (WORD_WIDTH'(0) - folded) : folded);
                  // entry below the top becomes the new top
                  tos_in   = below_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // end of expression: fold what is pending and flag an error or unbalanced nesting
   assign final_sum = sum_in + (neg_in ? (WORD_WIDTH'(0) - cur_in) : cur_in);
   assign final_err = err_in || (level_in != '0);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (fire && op_item.last) begin
         rsp_valid_in         = 1'b1;
         rsp_payload_in.total = final_err ? '0 : $signed(final_sum);
         rsp_payload_in.error = final_err;
      end
   end

   // keep the entry two below the next level prefetched
   assign rd_level = level_in - LW'(2);
   assign rd_addr  = rd_level[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cur_ff       <= '0;
         neg_ff       <= 1'b0;
         level_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire && op_item.last) begin
            sum_ff   <= '0;
            cur_ff   <= '0;
            neg_ff   <= 1'b0;
            level_ff <= '0;
            err_ff   <= 1'b0;
         end else begin
            sum_ff   <= sum_in;
            cur_ff   <= cur_in;
            neg_ff   <= neg_in;
            level_ff <= level_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff         <= tos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      below_ff <= mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(DEPTH))
      else $error("nesting level beyond stack depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.error |-> rsp_payload_ff.total == '0)
      else $error("error result carries a nonzero total");

   assert property (@(posedge clock) disable iff (reset)
      fire && op_item.last |=> level_ff == '0 && sum_ff == '0 && cur_ff == '0 && !err_ff)
      else $error("state not cleared after end of expression");

   assert property (@(posedge clock) disable iff (reset)
      fire && !op_item.last && op_item.op == OP_OPEN && level_ff != LW'(DEPTH)
      |=> level_ff == $past(level_ff) + 1'b1 && sum_ff == '0)
      else $error("open parenthesis did not push");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

FILE: src/paren_add_sub_expression_evaluator.sv
// top level of the add/subtract expression evaluator with parentheses
//
// usage:
//  - req channel: one ascii character per request, last_char marks the end of
//    an expression; digits build a number, + and - set the sign of the next
//    term, ( and ) nest, everything else is ignored
//  - rsp channel: one result per expression, total (32-bit, wraps) and error
//    (unbalanced parentheses or nesting deeper than DEPTH); total is 0 on error
//  - throughput: one request per cycle while each last character finds a free
//    output slot; set by the back end execute step and its stack top register
//  - the last request is written into the queue, then executes from there
//    straight into the output register, where the result becomes valid
//  - a 2-entry queue separates decode from execute, and the result sits in an
//    output register, so requests keep flowing while a result waits
//  - when rsp_ready is low with a result pending, the next last character
//    waits in the queue; once the queue fills, req_ready drops
//  - reset is synchronous and active high; it empties the queue, drops any
//    pending result and clears the sums and nesting level; stack memory is
//    not cleared and needs no clearing pass
module paren_add_sub_expression_evaluator
   import pae_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // decoded operation stream between front and back
   logic        op_valid;
   logic        op_ready;
   op_item_type op_item;

   pae_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .op_valid    (op_valid),
      .op_ready    (op_ready),
      .op_item     (op_item)
   );

   pae_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op_ready    (op_ready),
      .op_item     (op_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/paren_add_sub_expression_evaluator_tb.sv
// self-checking testbench for the add/subtract expression evaluator with parentheses
module paren_add_sub_expression_evaluator_tb;
   import pae_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no request or result taken before the run is given up
   localparam int STALL_LIMIT = 3000;
   // one long hold-off on the result side, so the queue fills and req_ready drops
   localparam int LONG_HOLD = 400;
   // the evaluator ignores blanks, but the stimulus uses them on purpose
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // running model of the evaluator plus the queue of totals still owed by the block
   class expression_scoreboard;
      logic [31:0] sum_so_far;
      logic [31:0] number_so_far;
      logic        minus_pending;
      logic [31:0] outer_sums [DEPTH_DEFAULT];
      logic        outer_minus [DEPTH_DEFAULT];
      int unsigned depth_now;
      logic        bad_syntax;
      rsp_type     totals_owed [$];
      int          failures;
      int          results_checked;

      function new();
         failures = 0;
         results_checked = 0;
         clear_expression();
      endfunction

      function void clear_expression();
         sum_so_far = '0;
         number_so_far = '0;
         minus_pending = 1'b0;
         depth_now = 0;
         bad_syntax = 1'b0;
      endfunction

      function logic [31:0] apply_sign(logic negate, logic [31:0] value);
         return negate ? (32'd0 - value) : value;
      endfunction

      function void add_pending_term();
         sum_so_far = sum_so_far + apply_sign(minus_pending, number_so_far);
         number_so_far = '0;
      endfunction

      function void take_character(req_type item);
         rsp_type result;
         logic [7:0] c;
         c = item.character;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            number_so_far = number_so_far * 32'd10 + 32'(c - CHAR_ZERO);
         end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            add_pending_term();
            minus_pending = (c == CHAR_MINUS);
         end else if (c == CHAR_OPEN) begin
            add_pending_term();
            if (depth_now >= DEPTH_DEFAULT) begin
               bad_syntax = 1'b1;
            end else begin
               outer_sums[depth_now] = sum_so_far;
               outer_minus[depth_now] = minus_pending;
               depth_now++;
               sum_so_far = '0;
               minus_pending = 1'b0;
            end
         end else if (c == CHAR_CLOSE) begin
            add_pending_term();
            if (depth_now == 0) begin
               bad_syntax = 1'b1;
            end else begin
               depth_now--;
               sum_so_far = outer_sums[depth_now]
                  + apply_sign(outer_minus[depth_now], sum_so_far);
            end
            minus_pending = 1'b0;
         end
         if (item.last_char) begin
            add_pending_term();
            result.error = bad_syntax || (depth_now != 0);
            result.total = result.error ? '0 : sum_so_far;
            totals_owed.push_back(result);
            clear_expression();
         end
      endfunction

      function void check_total(rsp_type got);
         rsp_type want;
         results_checked++;
         if (totals_owed.size() == 0) begin
            $error("result with no expression pending: total %0d error %0b",
                   got.total, got.error);
            failures++;
            return;
         end
         want = totals_owed.pop_front();
         if (got.total !== want.total) begin
            $error("total: expected %0d, got %0d", want.total, got.total);
            failures++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, got.error);
            failures++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   expression_scoreboard sb = new();

   // characters of the expression being built, sent front to back
   logic [7:0] expr_chars [$];
   // every request sent, skipped bytes included
   int items_sent = 0;
   int expressions_sent = 0;
   // when set, neither side inserts gaps
   bit steady = 1'b0;
   int stalled_cycles = 0;

   paren_add_sub_expression_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // synchronous reset held from the start, released on a falling edge
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // mostly back to back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit is_significant(logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS || c == CHAR_MINUS
         || c == CHAR_OPEN || c == CHAR_CLOSE;
   endfunction

   // a blank or any other byte the evaluator skips
   function automatic logic [7:0] ignored_char();
      logic [7:0] c;
      c = ($urandom_range(0, 3) == 0) ? CHAR_SPACE : 8'($urandom_range(0, 255));
      while (is_significant(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic [7:0] random_sign();
      return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
   endfunction

   // one request: optional gap, then valid held with a stable payload until taken
   task automatic send_request(input req_type item);
      int idle;
      idle = pick_gap();
      @(negedge clock);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.take_character(item);
   endtask

   // sends expr_chars with last_char on the final one
   task automatic send_expression();
      req_type item;
      foreach (expr_chars[i]) begin
         item.character = expr_chars[i];
         item.last_char = (i == expr_chars.size() - 1);
         send_request(item);
         items_sent++;
      end
      expressions_sent++;
   endtask

   task automatic send_text(input string s);
      expr_chars.delete();
      for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
      send_expression();
   endtask

   // short numbers mostly; long ones can overflow 32 bits and wrap
   task automatic add_number();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
      for (int d = 0; d < len; d++) begin
         expr_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         // skipped bytes inside a number must not split it
         if ($urandom_range(0, 15) == 0) expr_chars.push_back(ignored_char());
      end
   endtask

   // balanced expression with random terms, signs and nesting up to four deep
   task automatic build_well_formed();
      int terms;
      int open_count;
      terms = $urandom_range(1, 6);
      open_count = 0;
      if ($urandom_range(0, 3) == 0) expr_chars.push_back(random_sign());
      for (int t = 0; t < terms; t++) begin
         if (t > 0) expr_chars.push_back(random_sign());
         if ($urandom_range(0, 5) == 0) expr_chars.push_back(CHAR_SPACE);
         if (open_count < 4 && $urandom_range(0, 3) == 0) begin
            expr_chars.push_back(CHAR_OPEN);
            open_count++;
            if ($urandom_range(0, 3) == 0) expr_chars.push_back(random_sign());
         end
         add_number();
         if (open_count > 0 && $urandom_range(0, 2) == 0) begin
            expr_chars.push_back(CHAR_CLOSE);
            open_count--;
         end
      end
      repeat (open_count) expr_chars.push_back(CHAR_CLOSE);
      if ($urandom_range(0, 7) == 0) expr_chars.push_back(ignored_char());
   endtask

   // random soup of digits, operators, parentheses and arbitrary bytes
   task automatic build_broken();
      int len;
      int r;
      len = $urandom_range(1, 10);
      repeat (len) begin
         r = $urandom_range(0, 9);
         if (r < 4) expr_chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         else if (r < 5) expr_chars.push_back(CHAR_OPEN);
         else if (r < 6) expr_chars.push_back(CHAR_CLOSE);
         else if (r < 7) expr_chars.push_back(random_sign());
         else if (r < 8) expr_chars.push_back(CHAR_SPACE);
         else expr_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // nesting around the stack limit: 16 fits, 17 and more overflow
   task automatic build_deep();
      int opens;
      int closes;
      opens = $urandom_range(14, 18);
      repeat (opens) begin
         if ($urandom_range(0, 2) == 0) add_number();
         if ($urandom_range(0, 2) == 0) expr_chars.push_back(random_sign());
         expr_chars.push_back(CHAR_OPEN);
      end
      add_number();
      closes = $urandom_range(0, 3) == 0 ? $urandom_range(0, opens + 1) : opens;
      repeat (closes) begin
         expr_chars.push_back(CHAR_CLOSE);
         if ($urandom_range(0, 3) == 0) begin
            expr_chars.push_back(random_sign());
            add_number();
         end
      end
   endtask

   initial begin : stimulus
      int r;
      wait (!reset);

      // directed: digits before an open, minus then blank, blank inside a number,
      // negated group followed by digits, trailing sign, lone close, lone open
      send_text("2(3)");
      send_text("- 7");
      send_text("1 2");
      send_text("-(8)5");
      send_text("9+");
      send_text(")");
      send_text("(");
      // an expression of nothing but a skipped byte still yields a zero result
      expr_chars = '{8'hff};
      send_expression();
      expr_chars = '{8'h00};
      send_expression();

      // random part: mostly well-formed, some garbage, some deep nesting
      while (items_sent < 650 || expressions_sent < 60) begin
         if ($urandom_range(0, 29) == 0) steady = !steady;
         expr_chars.delete();
         r = $urandom_range(0, 99);
         if (r < 75) build_well_formed();
         else if (r < 88) build_broken();
         else build_deep();
         send_expression();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then keep the clock running so the pipeline can show any stray result
      while (sb.totals_owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // result side: ready stretches broken by random holds, one long hold-off
   initial begin : result_sink
      int ready_run;
      int hold;
      bit pressure_done;
      pressure_done = 1'b0;
      wait (!reset);
      forever begin
         ready_run = $urandom_range(1, 16);
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (ready_run - 1) @(negedge clock);
         hold = pick_gap();
         if (!pressure_done && sb.results_checked >= 8) begin
            hold = LONG_HOLD;
            pressure_done = 1'b1;
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // result check and stall watchdog, both on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_total(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled_cycles <= 0;
         end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            stalled_cycles <= stalled_cycles + 1;
         end
      end
   end

endmodule
